// ===== design/hce_pkg.sv =====
// ----------------------------------------------------------------------------
// hce_pkg: shared types and tables for the Hack C-instruction encoder
// Character codes, parse phases, channel payloads and the comp lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package hce_pkg;

  localparam logic [7:0] CH_EQ   = 8'h3D;  // '='
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_MIN  = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS = 8'h2B;  // '+'
  localparam logic [7:0] CH_BANG = 8'h21;  // '!'
  localparam logic [7:0] CH_AMP  = 8'h26;  // '&'
  localparam logic [7:0] CH_BAR  = 8'h7C;  // '|'

  localparam int unsigned COMP_SLOTS = 3;
  localparam logic [2:0] COMP_LEN_SAT = 3'd4;
  localparam logic [1:0] JUMP_LEN_SAT = 2'd3;

  localparam logic [2:0] JMP_ALWAYS = 3'b111;
  localparam logic [2:0] JMP_NE     = 3'b101;
  localparam logic [2:0] C_PREFIX   = 3'b111;

  typedef enum logic [1:0] {
    PH_FIRST       = 2'd0,
    PH_COMP        = 2'd1,
    PH_JUMP_NODEST = 2'd2,
    PH_JUMP_DEST   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] line_char;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [15:0] instruction_word;
    logic        comp_recognized;
  } out_item_t;

  function automatic logic [7:0] fold_m(input logic [7:0] ch);
    return (ch == CH_M) ? CH_A : ch;
  endfunction

  // Returns {recognized, comp bits}; M reads as A.
  function automatic logic [6:0] comp_lookup(input logic [2:0] len, input logic [7:0] c0,
                                             input logic [7:0] c1, input logic [7:0] c2);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [6:0] res;
    a = fold_m(c0);
    b = fold_m(c1);
    c = fold_m(c2);
    res = 7'd0;
    case (len)
      3'd1: begin
        if (a == CH_ZERO)     res = {1'b1, 6'h2A};
        else if (a == CH_ONE) res = {1'b1, 6'h3F};
        else if (a == CH_D)   res = {1'b1, 6'h0C};
        else if (a == CH_A)   res = {1'b1, 6'h30};
      end
      3'd2: begin
        if (a == CH_MIN && b == CH_ONE)       res = {1'b1, 6'h3A};
        else if (a == CH_MIN && b == CH_D)    res = {1'b1, 6'h0F};
        else if (a == CH_MIN && b == CH_A)    res = {1'b1, 6'h33};
        else if (a == CH_BANG && b == CH_D)   res = {1'b1, 6'h0D};
        else if (a == CH_BANG && b == CH_A)   res = {1'b1, 6'h31};
      end
      3'd3: begin
        if (a == CH_D && b == CH_PLUS && c == CH_ONE)      res = {1'b1, 6'h1F};
        else if (a == CH_A && b == CH_PLUS && c == CH_ONE) res = {1'b1, 6'h37};
        else if (a == CH_D && b == CH_MIN && c == CH_ONE)  res = {1'b1, 6'h0E};
        else if (a == CH_A && b == CH_MIN && c == CH_ONE)  res = {1'b1, 6'h32};
        else if (a == CH_D && b == CH_PLUS && c == CH_A)   res = {1'b1, 6'h02};
        else if (a == CH_D && b == CH_MIN && c == CH_A)    res = {1'b1, 6'h13};
        else if (a == CH_A && b == CH_MIN && c == CH_D)    res = {1'b1, 6'h07};
        else if (a == CH_D && b == CH_AMP && c == CH_A)    res = {1'b1, 6'h00};
        else if (a == CH_D && b == CH_BAR && c == CH_A)    res = {1'b1, 6'h15};
      end
      default: res = 7'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/hack_c_instruction_encoder_core.sv =====
// ----------------------------------------------------------------------------
// hack_c_instruction_encoder_core: Hack C-instruction encoder
// Parses dest=comp;jump text one character per transfer and emits the word.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle when the output side keeps up. Each
// character first lands in an input register; from there it updates the
// parse state, and on the last character of a line the encoded word is written
// to the output register. The rate is set by that single pass from input
// register through the state update and comp table into the result register.
// The input stalls only while a finished result waits in the output register.
`default_nettype none

module hack_c_instruction_encoder_core import hce_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic       s1_valid_r;
  in_item_t   s1_data_r;
  logic       s1_go;
  logic       out_free;
  logic       out_valid_r;
  out_item_t  out_data_r;

  phase_t     phase_r, phase_upd, phase_nxt;
  logic [2:0] dest_r, dest_upd, dest_nxt;
  logic [7:0] comp_text_r [COMP_SLOTS];
  logic [7:0] comp_text_upd [COMP_SLOTS];
  logic [7:0] comp_text_nxt [COMP_SLOTS];
  logic [2:0] comp_len_r, comp_len_upd, comp_len_nxt;
  logic       comp_m_r, comp_m_upd, comp_m_nxt;
  logic [7:0] jump_head_r [3];
  logic [7:0] jump_head_upd [3];
  logic [7:0] jump_head_nxt [3];
  logic [1:0] jump_len_r, jump_len_upd, jump_len_nxt;
  logic [2:0] jump_bits_r, jump_bits_upd, jump_bits_nxt;

  logic [6:0]  comp_res;
  logic [2:0]  dest_field;
  logic [2:0]  jump_field;
  out_item_t   result;
  logic [7:0]  ch;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign ch       = s1_data_r.line_char;

  // Character parse: same step as the behavior for one character.
  always_comb begin
    phase_upd     = phase_r;
    dest_upd      = dest_r;
    comp_text_upd = comp_text_r;
    comp_len_upd  = comp_len_r;
    comp_m_upd    = comp_m_r;
    jump_head_upd = jump_head_r;
    jump_len_upd  = jump_len_r;
    jump_bits_upd = jump_bits_r;
    case (phase_r)
      PH_FIRST, PH_COMP: begin
        if (phase_r == PH_FIRST && ch == CH_EQ) begin
          comp_text_upd = '{default: 8'd0};
          comp_len_upd  = 3'd0;
          comp_m_upd    = 1'b0;
          phase_upd     = PH_COMP;
        end else if (ch == CH_SEMI) begin
          if (phase_r == PH_FIRST) begin
            dest_upd  = 3'd0;
            phase_upd = PH_JUMP_NODEST;
          end else begin
            phase_upd = PH_JUMP_DEST;
          end
        end else begin
          if (phase_r == PH_FIRST) begin
            if (ch == CH_A)      dest_upd = dest_r | 3'b100;
            else if (ch == CH_D) dest_upd = dest_r | 3'b010;
            else if (ch == CH_M) dest_upd = dest_r | 3'b001;
          end
          if (comp_len_r < 3'(COMP_SLOTS)) comp_text_upd[comp_len_r[1:0]] = ch;
          if (comp_len_r < COMP_LEN_SAT) comp_len_upd = comp_len_r + 3'd1;
          if (ch == CH_M) comp_m_upd = 1'b1;
        end
      end
      default: begin
        if (jump_len_r < JUMP_LEN_SAT) begin
          jump_head_upd[jump_len_r] = ch;
          jump_len_upd              = jump_len_r + 2'd1;
        end
        if (ch == CH_L)      jump_bits_upd = jump_bits_r | 3'b100;
        else if (ch == CH_E) jump_bits_upd = jump_bits_r | 3'b010;
        else if (ch == CH_G) jump_bits_upd = jump_bits_r | 3'b001;
      end
    endcase
  end

  // Encode from the updated state.
  always_comb begin
    comp_res = comp_lookup(comp_len_upd, comp_text_upd[0], comp_text_upd[1],
                           comp_text_upd[2]);
    dest_field = (phase_upd == PH_COMP || phase_upd == PH_JUMP_DEST) ? dest_upd : 3'd0;
    jump_field = 3'd0;
    if (phase_upd == PH_JUMP_NODEST || phase_upd == PH_JUMP_DEST) begin
      jump_field = jump_bits_upd;
      if (jump_len_upd == JUMP_LEN_SAT && jump_head_upd[0] == CH_J) begin
        if (jump_head_upd[1] == CH_M && jump_head_upd[2] == CH_P)      jump_field = JMP_ALWAYS;
        else if (jump_head_upd[1] == CH_N && jump_head_upd[2] == CH_E) jump_field = JMP_NE;
      end
    end
    result.instruction_word = {C_PREFIX, comp_m_upd, comp_res[5:0], dest_field, jump_field};
    result.comp_recognized  = comp_res[6];
  end

  // Advance state on a processed character; clear after the last one.
  always_comb begin
    phase_nxt     = phase_r;
    dest_nxt      = dest_r;
    comp_text_nxt = comp_text_r;
    comp_len_nxt  = comp_len_r;
    comp_m_nxt    = comp_m_r;
    jump_head_nxt = jump_head_r;
    jump_len_nxt  = jump_len_r;
    jump_bits_nxt = jump_bits_r;
    if (s1_go) begin
      if (s1_data_r.end_of_line) begin
        phase_nxt     = PH_FIRST;
        dest_nxt      = 3'd0;
        comp_text_nxt = '{default: 8'd0};
        comp_len_nxt  = 3'd0;
        comp_m_nxt    = 1'b0;
        jump_head_nxt = '{default: 8'd0};
        jump_len_nxt  = 2'd0;
        jump_bits_nxt = 3'd0;
      end else begin
        phase_nxt     = phase_upd;
        dest_nxt      = dest_upd;
        comp_text_nxt = comp_text_upd;
        comp_len_nxt  = comp_len_upd;
        comp_m_nxt    = comp_m_upd;
        jump_head_nxt = jump_head_upd;
        jump_len_nxt  = jump_len_upd;
        jump_bits_nxt = jump_bits_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_FIRST;
      dest_r      <= 3'd0;
      comp_text_r <= '{default: 8'd0};
      comp_len_r  <= 3'd0;
      comp_m_r    <= 1'b0;
      jump_head_r <= '{default: 8'd0};
      jump_len_r  <= 2'd0;
      jump_bits_r <= 3'd0;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (out_free) out_valid_r <= s1_go && s1_data_r.end_of_line;
      phase_r     <= phase_nxt;
      dest_r      <= dest_nxt;
      comp_text_r <= comp_text_nxt;
      comp_len_r  <= comp_len_nxt;
      comp_m_r    <= comp_m_nxt;
      jump_head_r <= jump_head_nxt;
      jump_len_r  <= jump_len_nxt;
      jump_bits_r <= jump_bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_data_r <= in_data;
    if (s1_go && s1_data_r.end_of_line) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/hce_checker.sv =====
// ----------------------------------------------------------------------------
// hce_checker: port-level checks for the Hack C-instruction encoder
// Watches the top-level ports and flags illegal result words and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module hce_checker import hce_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A pending result must stay until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled input transfer keeps its character.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.instruction_word[15:13] == C_PREFIX)
    else $error("C-instruction prefix missing");

  a_unrec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.comp_recognized |-> out_data.instruction_word[11:6] == 6'd0)
    else $error("unrecognized comp with nonzero comp bits");

  // Input backpressure only comes from a blocked output.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

endmodule

bind hack_c_instruction_encoder_core hce_checker u_hce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
